FILE: hdl/valve_eye_pulse_position_tracker_macros.svh
// ----------------------------------------------------------------------------
// Valve eye tracker assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef VALVE_EYE_PULSE_POSITION_TRACKER_MACROS_SVH
`define VALVE_EYE_PULSE_POSITION_TRACKER_MACROS_SVH

// same-cycle implication
`define VEPPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("valve eye tracker assertion failed");

// next-cycle implication
`define VEPPT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("valve eye tracker assertion failed");

`endif

FILE: hdl/veppt_pkg.sv
// ----------------------------------------------------------------------------
// Valve eye tracker package
// Item, result, state and register types, codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package veppt_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_EYE   = 3'd1;
    localparam logic [2:0] OP_DRIVE = 3'd2;
    localparam logic [2:0] OP_HALT  = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;

    localparam logic [1:0] REG_IMPULSE_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_EYE_HIGH_MIN    = 2'd1;
    localparam logic [1:0] REG_EYE_LOW_MIN     = 2'd2;
    localparam logic [1:0] REG_EYE_OFF_TIMEOUT = 2'd3;

    localparam logic [13:0] RST_IMPULSE_TIMEOUT = 14'd400;
    localparam logic [7:0]  RST_EYE_HIGH_MIN    = 8'd3;
    localparam logic [7:0]  RST_EYE_LOW_MIN     = 8'd3;
    localparam logic [7:0]  RST_EYE_OFF_TIMEOUT = 8'd30;

    typedef enum logic [1:0] {
        DIR_STOP  = 2'd0,
        DIR_OPEN  = 2'd1,
        DIR_CLOSE = 2'd2
    } t_dir;

    typedef struct packed {
        logic [2:0]         op;
        logic               eye_level;
        logic               direction;
        logic signed [15:0] target;
        logic signed [15:0] value;
    } t_in;

    typedef struct packed {
        logic signed [15:0] position;
        logic               pulse_event;
        logic               stop_event;
        logic [1:0]         bridge_state;
        logic [15:0]        pulse_ticks;
        logic [7:0]         overshoot;
    } t_out;

    typedef struct packed {
        logic [13:0] impulse_timeout;
        logic [7:0]  eye_high_min;
        logic [7:0]  eye_low_min;
        logic [7:0]  eye_off_timeout;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] position;
        logic signed [15:0] stop_position;
        t_dir               drive_dir;
        t_dir               count_dir;
        logic [15:0]        tick_count;
        logic [15:0]        last_change;
        logic [15:0]        longest_low;
        logic [15:0]        pulse_timer;
        logic               eye_last;
        logic               eye_enabled;
        logic               bridge_on;
        logic [7:0]         overshoot_count;
        logic [15:0]        pulse_length;
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/veppt_core.sv
// ----------------------------------------------------------------------------
// Valve eye tracker update logic
// Next state and result for one item, from the current state and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module veppt_core (
    input  veppt_pkg::t_state i_state,
    input  veppt_pkg::t_cfg   i_cfg,
    input  veppt_pkg::t_in    i_item,
    output veppt_pkg::t_state o_state,
    output veppt_pkg::t_out   o_result
);
    import veppt_pkg::*;

    t_state             n;
    logic               pulse_ev;
    logic               stop_ev;
    logic [15:0]        tick_inc;
    logic [15:0]        dur;
    logic signed [15:0] pos_next;
    logic               qualified;
    t_dir               dir_cmd;

    always_comb begin
        case (i_state.count_dir)
            DIR_OPEN:  pos_next = i_state.position + 16'sd1;
            DIR_CLOSE: pos_next = i_state.position - 16'sd1;
            default:   pos_next = i_state.position;
        endcase
    end

    assign tick_inc  = i_state.tick_count + 16'd1;
    assign dur       = i_state.tick_count - i_state.last_change;
    assign qualified = (dur > {7'd0, i_cfg.eye_high_min, 1'b0}) &&
                       (i_state.longest_low > {7'd0, i_cfg.eye_low_min, 1'b0});
    assign dir_cmd   = i_item.direction ? DIR_CLOSE : DIR_OPEN;

    always_comb begin
        n        = i_state;
        pulse_ev = 1'b0;
        stop_ev  = 1'b0;
        case (i_item.op)
            OP_TICK: begin
                if (i_state.eye_enabled) begin
                    n.tick_count = tick_inc;
                    if (tick_inc[15:8] >= i_cfg.eye_off_timeout) begin
                        n.eye_enabled = 1'b0;
                        n.bridge_on   = 1'b0;
                    end else if (i_state.pulse_timer != 16'd0) begin
                        n.pulse_timer = i_state.pulse_timer - 16'd1;
                    end else if (i_state.bridge_on) begin
                        n.pulse_length = tick_inc;
                        stop_ev        = 1'b1;
                        n.bridge_on    = 1'b0;
                        n.drive_dir    = DIR_STOP;
                    end
                end
            end
            OP_EYE: begin
                if (i_state.eye_enabled && (i_item.eye_level != i_state.eye_last)) begin
                    n.last_change = i_state.tick_count;
                    if (!i_item.eye_level) begin
                        if (qualified) begin
                            n.position = pos_next;
                            if (!i_state.bridge_on) begin
                                n.overshoot_count = i_state.overshoot_count + 8'd1;
                            end
                            n.pulse_length = i_state.tick_count;
                            n.longest_low  = 16'd0;
                            n.tick_count   = 16'd0;
                            n.last_change  = 16'd0;
                            pulse_ev       = 1'b1;
                            if (pos_next == i_state.stop_position) begin
                                n.overshoot_count = 8'd0;
                                stop_ev           = 1'b1;
                                n.bridge_on       = 1'b0;
                                n.drive_dir       = DIR_STOP;
                            end else begin
                                n.pulse_timer = {2'b00, i_cfg.impulse_timeout};
                            end
                        end
                    end else if (dur > i_state.longest_low) begin
                        n.longest_low = dur;
                    end
                end
                n.eye_last = i_item.eye_level;
            end
            OP_DRIVE: begin
                n.stop_position = i_item.target;
                if (i_state.drive_dir != dir_cmd) begin
                    n.eye_enabled = 1'b1;
                    n.tick_count  = 16'd0;
                    n.last_change = 16'd0;
                    n.longest_low = 16'd0;
                    n.drive_dir   = dir_cmd;
                    n.count_dir   = dir_cmd;
                    n.pulse_timer = {i_cfg.impulse_timeout, 2'b00};
                    n.bridge_on   = 1'b1;
                end
            end
            OP_HALT: begin
                n.bridge_on = 1'b0;
                n.drive_dir = DIR_STOP;
            end
            OP_LOAD: begin
                n.position = i_item.value;
            end
            default: begin
            end
        endcase
    end

    assign o_state               = n;
    assign o_result.position     = n.position;
    assign o_result.pulse_event  = pulse_ev;
    assign o_result.stop_event   = stop_ev;
    assign o_result.bridge_state = n.bridge_on ? n.drive_dir : DIR_STOP;
    assign o_result.pulse_ticks  = n.pulse_length;
    assign o_result.overshoot    = n.overshoot_count;

endmodule

`default_nettype wire

FILE: hdl/valve_eye_pulse_position_tracker.sv
// ----------------------------------------------------------------------------
// Valve eye pulse position tracker
// Counts qualified photo-eye pulses of a valve motor and tracks position.
// ----------------------------------------------------------------------------
// Input register, then update logic, then result register, which holds the valid result.
// Throughput: one item per cycle while the result register is not stalled.
// Reset (synchronous, active low): position, counters and flags cleared,
// bridge off, registers at their defaults, both pipeline stages empty.
`default_nettype none

module valve_eye_pulse_position_tracker (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  veppt_pkg::t_in   i_in_data,
    output logic             o_valid,
    input  wire              i_ready,
    output veppt_pkg::t_out  o_out_data,
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire  [3:0]       paddr,
    input  wire  [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import veppt_pkg::*;

    logic   r_in_valid;
    t_in    r_in;
    logic   r_out_valid;
    t_out   r_out;
    t_state r_state;
    t_cfg   r_cfg;

    t_state n_state;
    t_out   n_out;
    logic   advance;
    logic   cfg_wr;

    veppt_core u_core (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.impulse_timeout <= RST_IMPULSE_TIMEOUT;
            r_cfg.eye_high_min    <= RST_EYE_HIGH_MIN;
            r_cfg.eye_low_min     <= RST_EYE_LOW_MIN;
            r_cfg.eye_off_timeout <= RST_EYE_OFF_TIMEOUT;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_IMPULSE_TIMEOUT: r_cfg.impulse_timeout <= pwdata[13:0];
                REG_EYE_HIGH_MIN:    r_cfg.eye_high_min    <= pwdata[7:0];
                REG_EYE_LOW_MIN:     r_cfg.eye_low_min     <= pwdata[7:0];
                REG_EYE_OFF_TIMEOUT: r_cfg.eye_off_timeout <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_IMPULSE_TIMEOUT: prdata = {18'd0, r_cfg.impulse_timeout};
            REG_EYE_HIGH_MIN:    prdata = {24'd0, r_cfg.eye_high_min};
            REG_EYE_LOW_MIN:     prdata = {24'd0, r_cfg.eye_low_min};
            REG_EYE_OFF_TIMEOUT: prdata = {24'd0, r_cfg.eye_off_timeout};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/veppt_checker.sv
// ----------------------------------------------------------------------------
// Valve eye tracker port checker
// Watches the result channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "valve_eye_pulse_position_tracker_macros.svh"

module veppt_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             o_valid,
    input wire             i_ready,
    input veppt_pkg::t_out o_out_data
);
    import veppt_pkg::*;

    `VEPPT_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_out_data))
    `VEPPT_ASSERT_IMP(a_bridge_code, o_valid, o_out_data.bridge_state != 2'd3)
    `VEPPT_ASSERT_IMP(a_stop_bridge_off, o_valid && o_out_data.stop_event, o_out_data.bridge_state == DIR_STOP)
    `VEPPT_ASSERT_IMP(a_target_clears_overshoot, o_valid && o_out_data.stop_event && o_out_data.pulse_event, o_out_data.overshoot == 8'd0)

endmodule

bind valve_eye_pulse_position_tracker veppt_checker u_veppt_checker (.*);

`default_nettype wire

FILE: test/valve_eye_pulse_position_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve eye pulse position tracker testbench
// Sends tick, eye, drive, halt and load items through the valid/ready input.
// Every result is checked field by field against an in-bench tracker model.
// Configuration is written over APB between phases, with extreme settings
// included. A random run at the default settings comes first, then directed cases:
// target stop with wrap, halt, impulse timeout and eye-off timeout. Random pulse
// trains follow, with sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------

module valve_eye_pulse_position_tracker_test;

    import veppt_pkg::*;

    localparam int LATENCY     = 2;
    localparam int SETTLE      = LATENCY + 4;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;

    localparam logic [2:0] OP_SPARE_LO   = 3'd5;
    localparam logic [2:0] OP_SPARE_HI   = 3'd7;
    localparam logic       DIR_BIT_OPEN  = 1'b0;
    localparam logic       DIR_BIT_CLOSE = 1'b1;

    typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_TOGGLE} t_sink_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_in_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_state tracker;
    t_cfg   eye_cfg;
    t_out   expected_reports[$];

    logic hold_req = 1'b0;
    int   fail_count    = 0;
    int   checked_count = 0;
    int   item_count    = 0;
    int   active_count  = 0;
    int   pulse_count   = 0;
    int   stop_count    = 0;
    int   write_count   = 0;
    int   burst_left    = 1;
    int   idle_cycles   = 0;

    always #5 i_clk = ~i_clk;

    valve_eye_pulse_position_tracker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_data  (i_in_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // tracker model
    // ------------------------------------------------------------------------
    function automatic void stop_motor();
        tracker.bridge_on = 1'b0;
        tracker.drive_dir = DIR_STOP;
    endfunction

    function automatic t_out advance_tracker(input t_in it);
        t_out        res;
        logic [15:0] dur;
        logic [15:0] high_lim;
        logic [15:0] low_lim;
        t_dir        d;
        high_lim = {7'd0, eye_cfg.eye_high_min, 1'b0};
        low_lim  = {7'd0, eye_cfg.eye_low_min, 1'b0};
        res = '0;
        case (it.op)
            OP_TICK: begin
                if (tracker.eye_enabled) begin
                    tracker.tick_count = tracker.tick_count + 16'd1;
                    if (tracker.tick_count[15:8] >= eye_cfg.eye_off_timeout) begin
                        tracker.eye_enabled = 1'b0;
                        tracker.bridge_on   = 1'b0;
                    end else if (tracker.pulse_timer != 16'd0) begin
                        tracker.pulse_timer = tracker.pulse_timer - 16'd1;
                    end else if (tracker.bridge_on) begin
                        tracker.pulse_length = tracker.tick_count;
                        res.stop_event = 1'b1;
                        stop_motor();
                    end
                end
            end
            OP_EYE: begin
                if (tracker.eye_enabled && it.eye_level != tracker.eye_last) begin
                    dur = tracker.tick_count - tracker.last_change;
                    tracker.last_change = tracker.tick_count;
                    if (!it.eye_level) begin
                        if (dur > high_lim && tracker.longest_low > low_lim) begin
                            if (tracker.count_dir == DIR_OPEN)
                                tracker.position = tracker.position + 16'sd1;
                            else if (tracker.count_dir == DIR_CLOSE)
                                tracker.position = tracker.position - 16'sd1;
                            if (!tracker.bridge_on)
                                tracker.overshoot_count = tracker.overshoot_count + 8'd1;
                            tracker.pulse_length = tracker.tick_count;
                            tracker.longest_low  = '0;
                            tracker.tick_count   = '0;
                            tracker.last_change  = '0;
                            res.pulse_event = 1'b1;
                            if (tracker.position == tracker.stop_position) begin
                                tracker.overshoot_count = '0;
                                res.stop_event = 1'b1;
                                stop_motor();
                            end else begin
                                tracker.pulse_timer = {2'b00, eye_cfg.impulse_timeout};
                            end
                        end
                    end else if (dur > tracker.longest_low) begin
                        tracker.longest_low = dur;
                    end
                end
                tracker.eye_last = it.eye_level;
            end
            OP_DRIVE: begin
                d = it.direction ? DIR_CLOSE : DIR_OPEN;
                tracker.stop_position = it.target;
                if (tracker.drive_dir != d) begin
                    tracker.eye_enabled = 1'b1;
                    tracker.tick_count  = '0;
                    tracker.last_change = '0;
                    tracker.longest_low = '0;
                    tracker.drive_dir   = d;
                    tracker.count_dir   = d;
                    tracker.pulse_timer = {eye_cfg.impulse_timeout, 2'b00};
                    tracker.bridge_on   = 1'b1;
                end
            end
            OP_HALT: stop_motor();
            OP_LOAD: tracker.position = it.value;
            default: ;
        endcase
        res.position     = tracker.position;
        res.bridge_state = tracker.bridge_on ? tracker.drive_dir : DIR_STOP;
        res.pulse_ticks  = tracker.pulse_length;
        res.overshoot    = tracker.overshoot_count;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in rand_item(input logic [2:0] op);
        t_in it;
        it.op        = op;
        it.eye_level = 1'($urandom);
        it.direction = 1'($urandom);
        it.target    = 16'($urandom);
        it.value     = 16'($urandom);
        return it;
    endfunction

    task automatic send_item(input t_in it);
        t_out res;
        int   gap;
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        res = advance_tracker(it);
        expected_reports.push_back(res);
        item_count++;
        if (it.op <= OP_LOAD) active_count++;
        pulse_count += res.pulse_event;
        stop_count  += res.stop_event;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic tick_run(input int n);
        repeat (n) send_item(rand_item(OP_TICK));
    endtask

    task automatic eye_sample(input logic lvl);
        t_in it;
        it = rand_item(OP_EYE);
        it.eye_level = lvl;
        send_item(it);
    endtask

    task automatic drive_to(input logic dir, input logic signed [15:0] tgt);
        t_in it;
        it = rand_item(OP_DRIVE);
        it.direction = dir;
        it.target    = tgt;
        send_item(it);
    endtask

    task automatic load_position(input logic signed [15:0] val);
        t_in it;
        it = rand_item(OP_LOAD);
        it.value = val;
        send_item(it);
    endtask

    task automatic halt_motor();
        send_item(rand_item(OP_HALT));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_IMPULSE_TIMEOUT: eye_cfg.impulse_timeout = data[13:0];
            REG_EYE_HIGH_MIN:    eye_cfg.eye_high_min    = data[7:0];
            REG_EYE_LOW_MIN:     eye_cfg.eye_low_min     = data[7:0];
            REG_EYE_OFF_TIMEOUT: eye_cfg.eye_off_timeout = data[7:0];
            default: ;
        endcase
        write_count++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int imp, input int hi, input int lo, input int off);
        apb_write(REG_IMPULSE_TIMEOUT, 32'(imp));
        apb_write(REG_EYE_HIGH_MIN, 32'(hi));
        apb_write(REG_EYE_LOW_MIN, 32'(lo));
        apb_write(REG_EYE_OFF_TIMEOUT, 32'(off));
    endtask

    // one random motor event; pulse trains dominate, near targets make stops likely
    task automatic random_action();
        int  pick;
        int  lim_h;
        int  lim_l;
        int  lim_t;
        int  step;
        t_in it;
        pick  = $urandom_range(0, 99);
        lim_h = 2 * eye_cfg.eye_high_min + 3;
        lim_l = 2 * eye_cfg.eye_low_min + 3;
        lim_t = eye_cfg.impulse_timeout + 4;
        if (lim_h > 14) lim_h = 14;
        if (lim_l > 14) lim_l = 14;
        if (lim_t > 40) lim_t = 40;
        step = $urandom_range(0, 4);
        if (pick < 55) begin
            eye_sample(1'b1);
            tick_run($urandom_range(0, lim_h));
            eye_sample(1'b0);
            tick_run($urandom_range(0, lim_l));
        end else if (pick < 65) begin
            tick_run($urandom_range(1, lim_t));
        end else if (pick < 77) begin
            it = rand_item(OP_DRIVE);
            if ($urandom_range(0, 4) != 0)
                it.target = it.direction ? tracker.position - 16'(step)
                                         : tracker.position + 16'(step);
            send_item(it);
        end else if (pick < 82) begin
            halt_motor();
        end else if (pick < 87) begin
            it = rand_item(OP_LOAD);
            if ($urandom_range(0, 1))
                it.value = it.direction ? tracker.stop_position - 16'(step)
                                        : tracker.stop_position + 16'(step);
            send_item(it);
        end else if (pick < 92) begin
            eye_sample(1'($urandom));
        end else if (pick < 96) begin
            send_item(rand_item(3'($urandom)));
        end else begin
            send_item(rand_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))));
        end
    endtask

    task automatic run_random(input int n);
        int start;
        start = active_count;
        while (active_count - start < n) random_action();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_default_settings();
        run_random(80);
        wait_drained();
    endtask

    task automatic test_target_stop_and_wrap();
        set_config(1, 0, 0, 255);
        for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++) send_item(rand_item(3'(k)));
        eye_sample(1'b1);                       // high level: never counted as a pulse
        load_position(16'sh7fff);
        drive_to(DIR_BIT_OPEN, 16'sh8000);
        tick_run(1);
        eye_sample(1'b0);                       // no low phase yet, not counted
        tick_run(1);
        eye_sample(1'b1);
        tick_run(1);
        eye_sample(1'b0);                       // wraps onto target
        load_position(16'sh7fff);
        tick_run(1);
        eye_sample(1'b1);
        tick_run(1);
        eye_sample(1'b0);                       // target again with bridge off
        wait_drained();
    endtask

    task automatic test_halt_and_impulse_timeout();
        drive_to(DIR_BIT_CLOSE, 16'sd0);
        halt_motor();
        tick_run(1);
        eye_sample(1'b1);
        drive_to(DIR_BIT_CLOSE, 16'sd0);
        drive_to(DIR_BIT_CLOSE, 16'sd5);        // same direction, target only
        tick_run(5);
        wait_drained();
    endtask

    task automatic test_eye_off_timeout();
        set_config(0, 0, 0, 0);
        drive_to(DIR_BIT_OPEN, 16'sd3);
        tick_run(1);
        drive_to(DIR_BIT_OPEN, 16'sd3);         // direction kept, no restart
        tick_run(1);
        eye_sample(1'b0);
        drive_to(DIR_BIT_CLOSE, -16'sd3);
        tick_run(1);
        wait_drained();
    endtask

    task automatic test_upper_limits();
        set_config(16383, 255, 255, 255);
        run_random(60);
        wait_drained();
    endtask

    task automatic test_random_motion();
        repeat (5) begin
            set_config($urandom_range(1, 24), $urandom_range(0, 3),
                       $urandom_range(0, 3), $urandom_range(1, 2));
            run_random(80);
            wait_drained();
        end
    endtask

    task automatic test_output_stall();
        hold_req = 1'b1;
        run_random(40);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // result sink with its own stall pattern
    // ------------------------------------------------------------------------
    initial begin : result_sink
        t_sink_mode sink_mode;
        int         span;
        i_ready = 1'b0;
        forever begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            span      = $urandom_range(16, 120);
            repeat (span) begin
                @(negedge i_clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    i_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                case (sink_mode)
                    SINK_OPEN:   i_ready <= 1'b1;
                    SINK_HALF:   i_ready <= 1'($urandom);
                    SINK_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:     i_ready <= ~i_ready;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // result check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_out want;
        t_out got;
        if (i_rst_n && o_valid && i_ready) begin
            got = o_out_data;
            if (expected_reports.size() == 0) begin
                if (fail_count < 10)
                    $display("%0t: result with no pending transfer: pos=%0d", $realtime,
                             got.position);
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                checked_count++;
                if (got.position !== want.position || got.pulse_event !== want.pulse_event ||
                    got.stop_event !== want.stop_event ||
                    got.bridge_state !== want.bridge_state ||
                    got.pulse_ticks !== want.pulse_ticks || got.overshoot !== want.overshoot) begin
                    if (fail_count < 10) begin
                        $display("%0t: result %0d exp pos=%0d pulse=%b stop=%b br=%0d tk=%0d ov=%0d",
                                 $realtime, checked_count, want.position, want.pulse_event,
                                 want.stop_event, want.bridge_state, want.pulse_ticks,
                                 want.overshoot);
                        $display("%0t: result %0d got pos=%0d pulse=%b stop=%b br=%0d tk=%0d ov=%0d",
                                 $realtime, checked_count, got.position, got.pulse_event,
                                 got.stop_event, got.bridge_state, got.pulse_ticks,
                                 got.overshoot);
                    end
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles without any transfer
    // ------------------------------------------------------------------------
    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_in_data = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        tracker   = '0;
        tracker.drive_dir = DIR_STOP;
        tracker.count_dir = DIR_STOP;
        eye_cfg.impulse_timeout = RST_IMPULSE_TIMEOUT;
        eye_cfg.eye_high_min    = RST_EYE_HIGH_MIN;
        eye_cfg.eye_low_min     = RST_EYE_LOW_MIN;
        eye_cfg.eye_off_timeout = RST_EYE_OFF_TIMEOUT;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_settings();
        test_target_stop_and_wrap();
        test_halt_and_impulse_timeout();
        test_eye_off_timeout();
        test_upper_limits();
        test_random_motion();
        test_output_stall();

        if (expected_reports.size() != 0) begin
            $display("%0d expected results never arrived", expected_reports.size());
            fail_count += expected_reports.size();
        end
        $display("Sent %0d transfers (%0d motor events), %0d register writes, %0d results checked",
                 item_count, active_count, write_count, checked_count);
        $display("Model saw %0d counted pulses and %0d stops", pulse_count, stop_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
